### rtl/vvpu_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Velocity Verlet update package
// Types, constants and helpers shared by the front, the back and the top level.
// ----------------------------------------------------------------------------
package vvpu_pkg;

    // Fixed-point format of every stored and transported value.
    localparam int FRAC_BITS = 20;
    localparam int DATA_W    = 32;
    localparam int DT_W      = 20;
    localparam int BOX_W     = 31;

    // Item field widths.
    localparam int KIND_W = 2;
    localparam int PART_W = 10;
    localparam int AXIS_W = 2;
    localparam int TAG_W  = PART_W + AXIS_W;

    // Datapath widths.
    localparam int P1_W   = DATA_W + DT_W + 1;   // force * dt
    localparam int VS_W   = DATA_W + 1;          // velocity + half kick
    localparam int P2_W   = VS_W + DT_W + 1;     // (v + dv) * dt
    localparam int SAT_W  = DATA_W + 3;          // sums ahead of saturation

    localparam logic signed [P1_W-1:0] HALF_KICK_BIAS = P1_W'(1) << FRAC_BITS;
    localparam logic signed [P2_W-1:0] STEP_BIAS      = P2_W'(1) << (FRAC_BITS - 1);

    // Queue sizing.
    localparam int MID_DEPTH  = 4;
    localparam int OUT_DEPTH  = 8;
    localparam int OUT_CNT_W  = $clog2(OUT_DEPTH) + 1;
    localparam int CRD_W      = OUT_CNT_W + 1;

    // Configuration port.
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam logic REG_TIME_STEP = 1'b0;
    localparam logic REG_BOX_WIDTH = 1'b1;
    localparam logic [DT_W-1:0]  TIME_STEP_RST = 20'd1048;
    localparam logic [BOX_W-1:0] BOX_WIDTH_RST = 31'd10485760;

    // Input codes.
    localparam logic [KIND_W-1:0] KIND_DRIFT = 2'd0;
    localparam logic [KIND_W-1:0] KIND_KICK  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_LOAD  = 2'd2;
    localparam logic [AXIS_W-1:0] AXIS_X = 2'd0;
    localparam logic [AXIS_W-1:0] AXIS_Y = 2'd1;
    localparam logic [AXIS_W-1:0] AXIS_Z = 2'd2;

    typedef enum logic [1:0] {
        OP_DRIFT,
        OP_KICK,
        OP_LOAD,
        OP_NULL
    } t_op;

    typedef struct packed {
        t_op                      op;
        logic [PART_W-1:0]        particle;
        logic [AXIS_W-1:0]        axis;
        logic signed [DATA_W-1:0] force_in;
        logic signed [DATA_W-1:0] position_in;
        logic signed [DATA_W-1:0] velocity_in;
    } t_cmd;

    typedef struct packed {
        logic signed [DATA_W-1:0] position;
        logic signed [DATA_W-1:0] velocity;
        logic signed [DATA_W-1:0] displacement;
        logic                     out_of_box;
    } t_result;

    typedef struct packed {
        logic [DT_W-1:0]  time_step;
        logic [BOX_W-1:0] box_width;
    } t_cfg;

    function automatic logic signed [DATA_W-1:0] sat32(input logic signed [SAT_W-1:0] x);
        logic signed [SAT_W-1:0] hi;
        logic signed [SAT_W-1:0] lo;
        hi = SAT_W'({1'b0, {(DATA_W-1){1'b1}}});
        lo = -hi - SAT_W'(1);
        if (x > hi) begin
            return {1'b0, {(DATA_W-1){1'b1}}};
        end else if (x < lo) begin
            return {1'b1, {(DATA_W-1){1'b0}}};
        end
        return x[DATA_W-1:0];
    endfunction

endpackage
`default_nettype wire

### rtl/vvpu_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Generic single-write, single-read RAM
// One write port and one read port with registered, read-first read data.
// ----------------------------------------------------------------------------
module vvpu_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

### rtl/vvpu_fifo.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Show-ahead FIFO
// Small register-based queue; the head entry is visible while not empty.
// ----------------------------------------------------------------------------
module vvpu_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_push,
    input  wire logic [WIDTH-1:0]         i_data,
    output logic                          o_full,
    input  wire logic                     i_pop,
    output logic      [WIDTH-1:0]         o_data,
    output logic                          o_empty,
    output logic      [$clog2(DEPTH):0]   o_count
);

    localparam int AW = $clog2(DEPTH);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wr_ptr;
    logic [AW-1:0]    r_rd_ptr;
    logic [AW:0]      r_count;
    logic [AW-1:0]    n_wr_ptr;
    logic [AW-1:0]    n_rd_ptr;
    logic [AW:0]      n_count;
    logic             w_do_push;
    logic             w_do_pop;

    assign o_full    = (r_count == (AW+1)'(DEPTH));
    assign o_empty   = (r_count == '0);
    assign w_do_push = i_push && !o_full;
    assign w_do_pop  = i_pop && !o_empty;

    always_comb begin
        n_wr_ptr = w_do_push ? r_wr_ptr + AW'(1) : r_wr_ptr;
        n_rd_ptr = w_do_pop ? r_rd_ptr + AW'(1) : r_rd_ptr;
        n_count  = r_count;
        if (w_do_push && !w_do_pop) begin
            n_count = r_count + (AW+1)'(1);
        end else if (w_do_pop && !w_do_push) begin
            n_count = r_count - (AW+1)'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    assign o_data  = r_mem[r_rd_ptr];
    assign o_count = r_count;

endmodule
`default_nettype wire

### rtl/vvpu_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Velocity Verlet update front end
// Accepts items, decodes them into operations and queues them for the back end.
// ----------------------------------------------------------------------------
module vvpu_front
    import vvpu_pkg::*;
#(
    parameter int PARTICLES = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_push,
    output logic                          o_full,
    input  wire logic [KIND_W-1:0]        i_kind,
    input  wire logic [PART_W-1:0]        i_particle,
    input  wire logic [AXIS_W-1:0]        i_axis,
    input  wire logic signed [DATA_W-1:0] i_force_in,
    input  wire logic signed [DATA_W-1:0] i_position_in,
    input  wire logic signed [DATA_W-1:0] i_velocity_in,
    output t_cmd                          o_cmd,
    output logic                          o_cmd_valid,
    input  wire logic                     i_cmd_pop
);

    localparam logic [16:0] PART_LIMIT = 17'(PARTICLES);

    t_op  w_op;
    t_cmd w_cmd;
    logic w_part_ok;
    logic w_empty;
    logic [$clog2(MID_DEPTH):0] w_count;

    assign w_part_ok = ({7'b0, i_particle} < PART_LIMIT);

    // Anything that addresses no component becomes a null operation, which
    // still yields an all-zero result in order.
    always_comb begin
        case (i_kind)
            KIND_DRIFT: w_op = OP_DRIFT;
            KIND_KICK:  w_op = OP_KICK;
            KIND_LOAD:  w_op = OP_LOAD;
            default:    w_op = OP_NULL;
        endcase
        if (!(i_axis inside {AXIS_X, AXIS_Y, AXIS_Z}) || !w_part_ok) begin
            w_op = OP_NULL;
        end
    end

    always_comb begin
        w_cmd.op          = w_op;
        w_cmd.particle    = i_particle;
        w_cmd.axis        = i_axis;
        w_cmd.force_in    = i_force_in;
        w_cmd.position_in = i_position_in;
        w_cmd.velocity_in = i_velocity_in;
    end

    vvpu_fifo #(
        .WIDTH ($bits(t_cmd)),
        .DEPTH (MID_DEPTH)
    ) u_cmd_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_push),
        .i_data  (w_cmd),
        .o_full  (o_full),
        .i_pop   (i_cmd_pop),
        .o_data  (o_cmd),
        .o_empty (w_empty),
        .o_count (w_count)
    );

    assign o_cmd_valid = !w_empty;

    a_count_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_count <= ($clog2(MID_DEPTH)+1)'(MID_DEPTH))
        else $error("command queue count exceeds its depth");

    a_full_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full && !i_cmd_pop |=> o_full)
        else $error("command queue left full without a pop");

    a_pop_not_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd_pop |-> o_cmd_valid)
        else $error("back end popped an empty command queue");

endmodule
`default_nettype wire

### rtl/vvpu_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Velocity Verlet update back end
// Four-stage read-modify-write pipeline over the particle state memories.
// ----------------------------------------------------------------------------
module vvpu_back
    import vvpu_pkg::*;
#(
    parameter int PARTICLES = 1024
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire t_cmd                 i_cmd,
    input  wire logic                 i_cmd_valid,
    output logic                      o_cmd_pop,
    input  wire t_cfg                 i_cfg,
    input  wire logic [OUT_CNT_W-1:0] i_res_count,
    output logic                      o_res_push,
    output t_result                   o_res
);

    localparam int ENTRIES = PARTICLES * 3;
    localparam int IDX_W   = $clog2(ENTRIES);

    // Issue
    logic [IDX_W-1:0] w_cand_idx;
    logic [TAG_W-1:0] w_cand_tag;
    logic             w_hazard;
    logic             w_credit_ok;
    logic [2:0]       w_inflight;
    logic             w_fire;

    // Stage 1: memory data arrives
    logic             r_s1_valid;
    t_cmd             r_s1_cmd;
    logic [IDX_W-1:0] r_s1_idx;
    logic signed [DATA_W-1:0] w_pos_q, w_vel_q, w_disp_q, w_frc_q;
    logic signed [P1_W-1:0]   w_mul1_a, w_mul1_b;
    logic signed [P1_W-1:0]   n_s2_prod1;
    logic signed [DATA_W-1:0] n_s2_pos, n_s2_vel, n_s2_disp, n_s2_frc;

    // Stage 2: half kick
    logic                     r_s2_valid;
    t_op                      r_s2_op;
    logic [TAG_W-1:0]         r_s2_tag;
    logic [IDX_W-1:0]         r_s2_idx;
    logic signed [P1_W-1:0]   r_s2_prod1;
    logic signed [DATA_W-1:0] r_s2_pos, r_s2_vel, r_s2_disp, r_s2_frc;
    logic signed [P1_W-1:0]   w_dv_full;
    logic signed [VS_W-1:0]   n_s3_vsum;
    logic signed [DATA_W-1:0] n_s3_vel;

    // Stage 3: drift product
    logic                     r_s3_valid;
    t_op                      r_s3_op;
    logic [TAG_W-1:0]         r_s3_tag;
    logic [IDX_W-1:0]         r_s3_idx;
    logic signed [VS_W-1:0]   r_s3_vsum;
    logic signed [DATA_W-1:0] r_s3_pos, r_s3_vel, r_s3_disp, r_s3_frc;
    logic signed [P2_W-1:0]   w_mul2_a, w_mul2_b;
    logic signed [P2_W-1:0]   n_s4_prod2;

    // Stage 4: final update and write-back
    logic                     r_s4_valid;
    t_op                      r_s4_op;
    logic [TAG_W-1:0]         r_s4_tag;
    logic [IDX_W-1:0]         r_s4_idx;
    logic signed [P2_W-1:0]   r_s4_prod2;
    logic signed [DATA_W-1:0] r_s4_pos, r_s4_vel, r_s4_disp, r_s4_frc;
    logic signed [P2_W-1:0]   w_step_full;
    logic signed [SAT_W-1:0]  w_step;
    logic signed [DATA_W-1:0] w_pos_drift, w_disp_drift;
    logic signed [VS_W-1:0]   w_x, w_w, w_xw;
    logic                     w_flag;
    t_result                  w_res;
    logic                     w_we;

    // ------------------------------------------------------------------ issue
    assign w_cand_idx = (IDX_W'(i_cmd.particle) << 1) + IDX_W'(i_cmd.particle)
                        + IDX_W'(i_cmd.axis);
    assign w_cand_tag = {i_cmd.particle, i_cmd.axis};

    // An item may not read a component that an older item still has to write.
    assign w_hazard = (i_cmd.op != OP_NULL) && (
        (r_s1_valid && r_s1_cmd.op != OP_NULL && {r_s1_cmd.particle, r_s1_cmd.axis} == w_cand_tag) ||
        (r_s2_valid && r_s2_op != OP_NULL && r_s2_tag == w_cand_tag) ||
        (r_s3_valid && r_s3_op != OP_NULL && r_s3_tag == w_cand_tag) ||
        (r_s4_valid && r_s4_op != OP_NULL && r_s4_tag == w_cand_tag));

    // Every issued item must find room in the result queue on leaving stage 4.
    assign w_inflight  = 3'(r_s1_valid) + 3'(r_s2_valid) + 3'(r_s3_valid) + 3'(r_s4_valid);
    assign w_credit_ok = (CRD_W'(i_res_count) + CRD_W'(w_inflight)) < CRD_W'(OUT_DEPTH);
    assign w_fire      = i_cmd_valid && !w_hazard && w_credit_ok;
    assign o_cmd_pop   = w_fire;

    // --------------------------------------------------------------- memories
    vvpu_ram #(.WIDTH(DATA_W), .DEPTH(ENTRIES)) u_pos_ram (
        .i_clk (i_clk), .i_we (w_we), .i_waddr (r_s4_idx), .i_wdata (w_res.position),
        .i_re (w_fire), .i_raddr (w_cand_idx), .o_rdata (w_pos_q)
    );
    vvpu_ram #(.WIDTH(DATA_W), .DEPTH(ENTRIES)) u_vel_ram (
        .i_clk (i_clk), .i_we (w_we), .i_waddr (r_s4_idx), .i_wdata (w_res.velocity),
        .i_re (w_fire), .i_raddr (w_cand_idx), .o_rdata (w_vel_q)
    );
    vvpu_ram #(.WIDTH(DATA_W), .DEPTH(ENTRIES)) u_disp_ram (
        .i_clk (i_clk), .i_we (w_we), .i_waddr (r_s4_idx), .i_wdata (w_res.displacement),
        .i_re (w_fire), .i_raddr (w_cand_idx), .o_rdata (w_disp_q)
    );
    vvpu_ram #(.WIDTH(DATA_W), .DEPTH(ENTRIES)) u_frc_ram (
        .i_clk (i_clk), .i_we (w_we), .i_waddr (r_s4_idx), .i_wdata (r_s4_frc),
        .i_re (w_fire), .i_raddr (w_cand_idx), .o_rdata (w_frc_q)
    );

    // ---------------------------------------------------------------- stage 1
    // A load passes through with a zero product so that it leaves its
    // velocity untouched.
    always_comb begin
        case (r_s1_cmd.op)
            OP_DRIFT: w_mul1_a = P1_W'(w_frc_q);
            OP_KICK:  w_mul1_a = P1_W'(r_s1_cmd.force_in);
            default:  w_mul1_a = '0;
        endcase
        w_mul1_b   = P1_W'({1'b0, i_cfg.time_step});
        n_s2_prod1 = w_mul1_a * w_mul1_b;
        if (r_s1_cmd.op == OP_LOAD) begin
            n_s2_pos  = r_s1_cmd.position_in;
            n_s2_vel  = r_s1_cmd.velocity_in;
            n_s2_disp = '0;
        end else begin
            n_s2_pos  = w_pos_q;
            n_s2_vel  = w_vel_q;
            n_s2_disp = w_disp_q;
        end
        n_s2_frc = (r_s1_cmd.op == OP_DRIFT) ? w_frc_q : r_s1_cmd.force_in;
    end

    // ---------------------------------------------------------------- stage 2
    always_comb begin
        w_dv_full = (r_s2_prod1 + HALF_KICK_BIAS) >>> (FRAC_BITS + 1);
        n_s3_vsum = VS_W'(r_s2_vel) + w_dv_full[VS_W-1:0];
        n_s3_vel  = sat32(SAT_W'(n_s3_vsum));
    end

    // ---------------------------------------------------------------- stage 3
    always_comb begin
        w_mul2_a   = P2_W'(r_s3_vsum);
        w_mul2_b   = P2_W'({1'b0, i_cfg.time_step});
        n_s4_prod2 = w_mul2_a * w_mul2_b;
    end

    // ---------------------------------------------------------------- stage 4
    always_comb begin
        w_step_full  = (r_s4_prod2 + STEP_BIAS) >>> FRAC_BITS;
        w_step       = w_step_full[SAT_W-1:0];
        w_pos_drift  = sat32(SAT_W'(r_s4_pos) + w_step);
        w_disp_drift = sat32(SAT_W'(r_s4_disp) + w_step);

        // A single add or subtract of the box edge; anything further out
        // stays out and is flagged.
        w_x = VS_W'(r_s4_pos);
        w_w = VS_W'({1'b0, i_cfg.box_width});
        if (w_x < 0) begin
            w_xw = w_x + w_w;
        end else if (w_x >= w_w) begin
            w_xw = w_x - w_w;
        end else begin
            w_xw = w_x;
        end
        w_flag = (w_xw < 0) || (w_xw >= w_w);

        w_res = '0;
        case (r_s4_op)
            OP_DRIFT: begin
                w_res.position     = w_pos_drift;
                w_res.velocity     = r_s4_vel;
                w_res.displacement = w_disp_drift;
            end
            OP_KICK: begin
                w_res.position     = w_xw[DATA_W-1:0];
                w_res.velocity     = r_s4_vel;
                w_res.displacement = r_s4_disp;
                w_res.out_of_box   = w_flag;
            end
            OP_LOAD: begin
                w_res.position     = r_s4_pos;
                w_res.velocity     = r_s4_vel;
                w_res.displacement = r_s4_disp;
            end
            default: w_res = '0;
        endcase
    end

    assign w_we       = r_s4_valid && (r_s4_op != OP_NULL);
    assign o_res_push = r_s4_valid;
    assign o_res      = w_res;

    // -------------------------------------------------------------- registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_s3_valid <= 1'b0;
            r_s4_valid <= 1'b0;
        end else begin
            r_s1_valid <= w_fire;
            r_s2_valid <= r_s1_valid;
            r_s3_valid <= r_s2_valid;
            r_s4_valid <= r_s3_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_cmd   <= i_cmd;
        r_s1_idx   <= w_cand_idx;

        r_s2_op    <= r_s1_cmd.op;
        r_s2_tag   <= {r_s1_cmd.particle, r_s1_cmd.axis};
        r_s2_idx   <= r_s1_idx;
        r_s2_prod1 <= n_s2_prod1;
        r_s2_pos   <= n_s2_pos;
        r_s2_vel   <= n_s2_vel;
        r_s2_disp  <= n_s2_disp;
        r_s2_frc   <= n_s2_frc;

        r_s3_op    <= r_s2_op;
        r_s3_tag   <= r_s2_tag;
        r_s3_idx   <= r_s2_idx;
        r_s3_vsum  <= n_s3_vsum;
        r_s3_pos   <= r_s2_pos;
        r_s3_vel   <= n_s3_vel;
        r_s3_disp  <= r_s2_disp;
        r_s3_frc   <= r_s2_frc;

        r_s4_op    <= r_s3_op;
        r_s4_tag   <= r_s3_tag;
        r_s4_idx   <= r_s3_idx;
        r_s4_prod2 <= n_s4_prod2;
        r_s4_pos   <= r_s3_pos;
        r_s4_vel   <= r_s3_vel;
        r_s4_disp  <= r_s3_disp;
        r_s4_frc   <= r_s3_frc;
    end

    // ------------------------------------------------------------- assertions
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s4_valid |-> $past(w_fire, 4))
        else $error("result leaves the pipeline without a matching issue");

    a_no_stale_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_fire && i_cmd.op != OP_NULL && w_we |-> r_s4_tag != w_cand_tag)
        else $error("component read while its write-back is still pending");

    a_null_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s4_valid && r_s4_op == OP_NULL |-> w_res == '0 && !w_we)
        else $error("null operation produced data or a write");

endmodule
`default_nettype wire

### rtl/velocity_verlet_periodic_update.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Velocity Verlet periodic update
// Streams drift, kick-and-wrap and load operations over stored particle state.
//
// Items enter through a queue-style port (push/full) and results leave through
// another (empty/pop); exactly one result comes out per item, in order.
// Configuration (time step, box width) is written over the APB port, pready
// tied high; the user must write it only while the block is idle, which the
// block does not enforce. Throughput is one item per cycle while the result
// queue has room, set by the four-stage read-modify-write pipeline around
// the state memories: an item that addresses the same particle component as
// one of the four items ahead of it waits until that item has written back.
// Reset empties both queues and the pipeline and restores the default time
// step and box width. The state memories are not cleared: a component must
// be loaded before it is drifted or kicked.
// When the receiver stops popping, up to eight results are held; the back
// end then stops issuing, the 4-entry command queue fills and full rises.
// ----------------------------------------------------------------------------
module velocity_verlet_periodic_update
    import vvpu_pkg::*;
#(
    parameter int PARTICLES = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    // configuration
    input  wire logic                     psel,
    input  wire logic                     penable,
    input  wire logic                     pwrite,
    input  wire logic [APB_ADDR_W-1:0]    paddr,
    input  wire logic [APB_DATA_W-1:0]    pwdata,
    output logic      [APB_DATA_W-1:0]    prdata,
    output logic                          pready,
    // items
    input  wire logic                     push,
    output logic                          full,
    input  wire logic [KIND_W-1:0]        i_kind,
    input  wire logic [PART_W-1:0]        i_particle,
    input  wire logic [AXIS_W-1:0]        i_axis,
    input  wire logic signed [DATA_W-1:0] i_force_in,
    input  wire logic signed [DATA_W-1:0] i_position_in,
    input  wire logic signed [DATA_W-1:0] i_velocity_in,
    // results
    output logic                          empty,
    input  wire logic                     pop,
    output logic signed [DATA_W-1:0]      o_position_out,
    output logic signed [DATA_W-1:0]      o_velocity_out,
    output logic signed [DATA_W-1:0]      o_displacement_out,
    output logic                          o_out_of_box
);

    logic [DT_W-1:0]  r_time_step;
    logic [BOX_W-1:0] r_box_width;
    t_cfg             w_cfg;
    t_cmd             w_cmd;
    logic             w_cmd_valid;
    logic             w_cmd_pop;
    logic             w_res_push;
    t_result          w_res;
    t_result          w_res_head;
    logic             w_res_full;
    logic [OUT_CNT_W-1:0] w_res_count;

    // ---------------------------------------------------------- configuration
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_time_step <= TIME_STEP_RST;
            r_box_width <= BOX_WIDTH_RST;
        end else if (psel && penable && pwrite) begin
            case (paddr[2])
                REG_TIME_STEP: r_time_step <= pwdata[DT_W-1:0];
                REG_BOX_WIDTH: r_box_width <= pwdata[BOX_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            REG_TIME_STEP: prdata = APB_DATA_W'(r_time_step);
            REG_BOX_WIDTH: prdata = APB_DATA_W'(r_box_width);
            default:       prdata = '0;
        endcase
    end

    assign w_cfg.time_step = r_time_step;
    assign w_cfg.box_width = r_box_width;

    // ------------------------------------------------------------------ parts
    vvpu_front #(.PARTICLES(PARTICLES)) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_push        (push),
        .o_full        (full),
        .i_kind        (i_kind),
        .i_particle    (i_particle),
        .i_axis        (i_axis),
        .i_force_in    (i_force_in),
        .i_position_in (i_position_in),
        .i_velocity_in (i_velocity_in),
        .o_cmd         (w_cmd),
        .o_cmd_valid   (w_cmd_valid),
        .i_cmd_pop     (w_cmd_pop)
    );

    vvpu_back #(.PARTICLES(PARTICLES)) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .i_cmd_valid (w_cmd_valid),
        .o_cmd_pop   (w_cmd_pop),
        .i_cfg       (w_cfg),
        .i_res_count (w_res_count),
        .o_res_push  (w_res_push),
        .o_res       (w_res)
    );

    vvpu_fifo #(
        .WIDTH ($bits(t_result)),
        .DEPTH (OUT_DEPTH)
    ) u_res_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_res_push),
        .i_data  (w_res),
        .o_full  (w_res_full),
        .i_pop   (pop),
        .o_data  (w_res_head),
        .o_empty (empty),
        .o_count (w_res_count)
    );

    assign o_position_out     = w_res_head.position;
    assign o_velocity_out     = w_res_head.velocity;
    assign o_displacement_out = w_res_head.displacement;
    assign o_out_of_box       = w_res_head.out_of_box;

    // ------------------------------------------------------------- assertions
    a_result_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_res_push |-> !w_res_full)
        else $error("result dropped: result queue full on write-back");

endmodule
`default_nettype wire

### verif/velocity_verlet_periodic_update_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Velocity Verlet periodic update testbench
// Sends load, drift and kick-and-wrap transactions with random gaps on both
// sides. A local model of the particle state, or a directed row, predicts
// each result, compared field by field. The time step and box width
// change between phases, the extremes among them. Once, the result side holds
// off long enough for the block to fill up and stall its input.
// ----------------------------------------------------------------------------
module velocity_verlet_periodic_update_test;
    import vvpu_pkg::*;

    localparam int PARTICLES     = 1024;
    localparam int ENTRIES       = PARTICLES * 3;
    localparam int HOT_PARTICLES = 8;
    localparam int MAX_GAP       = 16;
    localparam int SETTLE_CYCLES = 16;
    localparam int HOLD_CYCLES   = 300;
    localparam int CYCLE_LIMIT   = 400000;

    localparam logic [KIND_W-1:0]     KIND_UNUSED    = 2'd3;
    localparam logic [AXIS_W-1:0]     AXIS_NONE      = 2'd3;
    localparam logic [APB_ADDR_W-1:0] ADDR_TIME_STEP = {REG_TIME_STEP, 2'b00};
    localparam logic [APB_ADDR_W-1:0] ADDR_BOX_WIDTH = {REG_BOX_WIDTH, 2'b00};

    localparam logic signed [63:0] S32_MAX = 64'sd2147483647;
    localparam logic signed [63:0] S32_MIN = -64'sd2147483648;
    localparam int VAL_MAX = 32'sh7FFFFFFF;
    localparam int VAL_MIN = 32'sh80000000;

    typedef struct packed {
        logic [KIND_W-1:0]        kind;
        logic [PART_W-1:0]        particle;
        logic [AXIS_W-1:0]        axis;
        logic signed [DATA_W-1:0] force_v;
        logic signed [DATA_W-1:0] pos_v;
        logic signed [DATA_W-1:0] vel_v;
    } t_motion;

    typedef struct {
        t_motion cmd;
        bit      typed;
        t_result want;
    } t_stim_row;

    logic                     i_clk         = 1'b0;
    logic                     i_rst_n       = 1'b0;
    logic                     psel          = 1'b0;
    logic                     penable       = 1'b0;
    logic                     pwrite        = 1'b0;
    logic [APB_ADDR_W-1:0]    paddr         = '0;
    logic [APB_DATA_W-1:0]    pwdata        = '0;
    logic [APB_DATA_W-1:0]    prdata;
    logic                     pready;
    logic                     push          = 1'b0;
    logic                     full;
    logic [KIND_W-1:0]        i_kind        = '0;
    logic [PART_W-1:0]        i_particle    = '0;
    logic [AXIS_W-1:0]        i_axis        = '0;
    logic signed [DATA_W-1:0] i_force_in    = '0;
    logic signed [DATA_W-1:0] i_position_in = '0;
    logic signed [DATA_W-1:0] i_velocity_in = '0;
    logic                     empty;
    logic                     pop           = 1'b0;
    logic signed [DATA_W-1:0] o_position_out;
    logic signed [DATA_W-1:0] o_velocity_out;
    logic signed [DATA_W-1:0] o_displacement_out;
    logic                     o_out_of_box;

    // Local copy of the particle state and the configuration.
    logic signed [DATA_W-1:0] pos_mem   [ENTRIES];
    logic signed [DATA_W-1:0] vel_mem   [ENTRIES];
    logic signed [DATA_W-1:0] disp_mem  [ENTRIES];
    logic signed [DATA_W-1:0] force_mem [ENTRIES];
    bit                       loaded    [ENTRIES];
    logic [DT_W-1:0]          cfg_time_step = TIME_STEP_RST;
    logic [BOX_W-1:0]         cfg_box_width = BOX_WIDTH_RST;

    t_result   expected_states[$];
    t_stim_row directed_rows[$];
    int        mismatches   = 0;
    int        cycle_count  = 0;
    bit        hold_request = 1'b0;
    bit        push_burst   = 1'b0;
    bit        pop_burst    = 1'b0;

    velocity_verlet_periodic_update #(
        .PARTICLES(PARTICLES)
    ) dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .psel               (psel),
        .penable            (penable),
        .pwrite             (pwrite),
        .paddr              (paddr),
        .pwdata             (pwdata),
        .prdata             (prdata),
        .pready             (pready),
        .push               (push),
        .full               (full),
        .i_kind             (i_kind),
        .i_particle         (i_particle),
        .i_axis             (i_axis),
        .i_force_in         (i_force_in),
        .i_position_in      (i_position_in),
        .i_velocity_in      (i_velocity_in),
        .empty              (empty),
        .pop                (pop),
        .o_position_out     (o_position_out),
        .o_velocity_out     (o_velocity_out),
        .o_displacement_out (o_displacement_out),
        .o_out_of_box       (o_out_of_box)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
    end

    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("velocity_verlet_periodic_update: mismatch");
        $finish;
    end

    function automatic logic signed [DATA_W-1:0] clamp32(input logic signed [63:0] x);
        if (x > S32_MAX) begin
            return S32_MAX[DATA_W-1:0];
        end else if (x < S32_MIN) begin
            return S32_MIN[DATA_W-1:0];
        end
        return x[DATA_W-1:0];
    endfunction

    // Round to nearest with ties towards plus infinity.
    function automatic logic signed [63:0] round_shr(input logic signed [63:0] x, input int s);
        return (x + (64'sd1 <<< (s - 1))) >>> s;
    endfunction

    function automatic logic signed [63:0] half_kick(input logic signed [DATA_W-1:0] f);
        logic signed [63:0] f64;
        logic signed [63:0] dt;
        f64 = f;
        dt  = 64'(cfg_time_step);
        return round_shr(f64 * dt, FRAC_BITS + 1);
    endfunction

    function automatic t_result integrate(input t_motion m);
        t_result            r;
        int                 k;
        logic signed [63:0] v;
        logic signed [63:0] dv;
        logic signed [63:0] dt;
        logic signed [63:0] step;
        logic signed [63:0] x;
        logic signed [63:0] w;
        r = '0;
        // Bad addresses and the unused kind leave the state alone.
        if (m.kind == KIND_UNUSED || m.axis == AXIS_NONE || int'(m.particle) >= PARTICLES) begin
            return r;
        end
        k  = int'(m.particle) * 3 + int'(m.axis);
        dt = 64'(cfg_time_step);
        w  = 64'(cfg_box_width);
        case (m.kind)
            KIND_DRIFT: begin
                v    = vel_mem[k];
                dv   = half_kick(force_mem[k]);
                step = round_shr((v + dv) * dt, FRAC_BITS);
                x    = pos_mem[k];
                pos_mem[k] = clamp32(x + step);
                x    = disp_mem[k];
                disp_mem[k] = clamp32(x + step);
                vel_mem[k]  = clamp32(v + dv);
            end
            KIND_KICK: begin
                force_mem[k] = m.force_v;
                v = vel_mem[k];
                vel_mem[k] = clamp32(v + half_kick(m.force_v));
                // A single add or subtract only; far-out positions stay out.
                x = pos_mem[k];
                if (x < 0) begin
                    x = x + w;
                end else if (x >= w) begin
                    x = x - w;
                end
                r.out_of_box = (x < 0 || x >= w);
                pos_mem[k] = clamp32(x);
            end
            KIND_LOAD: begin
                pos_mem[k]   = m.pos_v;
                vel_mem[k]   = m.vel_v;
                force_mem[k] = m.force_v;
                disp_mem[k]  = '0;
                loaded[k]    = 1'b1;
            end
            default: begin
            end
        endcase
        r.position     = pos_mem[k];
        r.velocity     = vel_mem[k];
        r.displacement = disp_mem[k];
        return r;
    endfunction

    function automatic logic signed [DATA_W-1:0] draw_scalar();
        int span;
        span = 1 << 24;
        if ($urandom_range(0, 3) == 0) begin
            return $urandom;
        end
        return $signed($urandom_range(0, 2 * span)) - span;
    endfunction

    // Mostly well-formed traffic on a few hot particles, so that components
    // are drifted and kicked back to back; loads come first on any component.
    function automatic t_motion draw_item();
        t_motion            m;
        int                 k;
        int                 pick;
        logic signed [63:0] x;
        logic signed [63:0] w;
        if ($urandom_range(0, 9) < 7) begin
            m.particle = PART_W'($urandom_range(0, HOT_PARTICLES - 1));
        end else begin
            m.particle = PART_W'($urandom);
        end
        m.axis    = AXIS_W'($urandom_range(0, 2));
        m.force_v = draw_scalar();
        m.vel_v   = draw_scalar();
        w = 64'(cfg_box_width);
        case ($urandom_range(0, 3))
            0: x = $signed($urandom);
            1: begin
                if (w == 0) begin
                    x = 64'($urandom_range(0, 1 << 24));
                end else begin
                    x = 64'($urandom_range(0, 32'(w - 1)));
                end
            end
            2: x = -64'($urandom_range(1, 1 << 24));
            default: x = w + 64'($urandom_range(0, 1 << 24));
        endcase
        m.pos_v = clamp32(x);
        k    = int'(m.particle) * 3 + int'(m.axis);
        pick = $urandom_range(0, 99);
        if (!loaded[k] || (pick >= 80 && pick < 90)) begin
            m.kind = KIND_LOAD;
        end else if (pick < 40) begin
            m.kind = KIND_DRIFT;
        end else if (pick < 80) begin
            m.kind = KIND_KICK;
        end else if ($urandom_range(0, 1) == 1) begin
            m.kind = KIND_UNUSED;
            m.axis = AXIS_W'($urandom);
        end else begin
            m.kind = KIND_W'($urandom_range(0, 2));
            m.axis = AXIS_NONE;
        end
        return m;
    endfunction

    task automatic note_mismatch(input string msg);
        mismatches++;
        $display("[%0t] %s", $time, msg);
    endtask

    task automatic add_row(input logic [KIND_W-1:0] kind, input int particle,
                           input logic [AXIS_W-1:0] axis, input int f, input int x,
                           input int v, input bit typed, input int wx, input int wv,
                           input int wd, input bit wf);
        t_stim_row row;
        row.cmd.kind           = kind;
        row.cmd.particle       = PART_W'(particle);
        row.cmd.axis           = axis;
        row.cmd.force_v        = f;
        row.cmd.pos_v          = x;
        row.cmd.vel_v          = v;
        row.typed              = typed;
        row.want.position      = wx;
        row.want.velocity      = wv;
        row.want.displacement  = wd;
        row.want.out_of_box    = wf;
        directed_rows.push_back(row);
    endtask

    task automatic send_item(input t_motion m, input bit typed, input t_result want);
        int      gap;
        t_result predicted;
        if ($urandom_range(0, 39) == 0) begin
            push_burst = !push_burst;
        end
        gap = push_burst ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        push          <= 1'b1;
        i_kind        <= m.kind;
        i_particle    <= m.particle;
        i_axis        <= m.axis;
        i_force_in    <= m.force_v;
        i_position_in <= m.pos_v;
        i_velocity_in <= m.vel_v;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        predicted = integrate(m);
        expected_states.push_back(typed ? want : predicted);
    endtask

    task automatic check_result();
        t_result want;
        if (expected_states.size() == 0) begin
            note_mismatch($sformatf("unexpected result, position_out %0d", o_position_out));
            return;
        end
        want = expected_states.pop_front();
        if (o_position_out !== want.position) begin
            note_mismatch($sformatf("position_out %0d, expected %0d",
                                    o_position_out, want.position));
        end
        if (o_velocity_out !== want.velocity) begin
            note_mismatch($sformatf("velocity_out %0d, expected %0d",
                                    o_velocity_out, want.velocity));
        end
        if (o_displacement_out !== want.displacement) begin
            note_mismatch($sformatf("displacement_out %0d, expected %0d",
                                    o_displacement_out, want.displacement));
        end
        if (o_out_of_box !== want.out_of_box) begin
            note_mismatch($sformatf("out_of_box %b, expected %b", o_out_of_box, want.out_of_box));
        end
    endtask

    task automatic drain_results();
        int gap;
        forever begin
            if ($urandom_range(0, 29) == 0) begin
                pop_burst = !pop_burst;
            end
            gap = pop_burst ? 0 : $urandom_range(0, MAX_GAP);
            if (hold_request) begin
                hold_request = 1'b0;
                gap = gap + HOLD_CYCLES;
            end
            if (gap > 0) begin
                pop <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            pop <= 1'b1;
            @(posedge i_clk);
            while (empty) @(posedge i_clk);
            check_result();
        end
    endtask

    task automatic wait_idle();
        push <= 1'b0;
        while (expected_states.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Write one register, then read it back.
    task automatic write_register(input logic [APB_ADDR_W-1:0] addr,
                                  input logic [APB_DATA_W-1:0] value);
        logic [APB_DATA_W-1:0] readback;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        if (addr == ADDR_TIME_STEP) begin
            cfg_time_step = value[DT_W-1:0];
        end else begin
            cfg_box_width = value[BOX_W-1:0];
        end
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        readback = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        if (addr == ADDR_TIME_STEP && readback[DT_W-1:0] !== cfg_time_step) begin
            note_mismatch($sformatf("time_step reads %0d, expected %0d",
                                    readback[DT_W-1:0], cfg_time_step));
        end
        if (addr == ADDR_BOX_WIDTH && readback[BOX_W-1:0] !== cfg_box_width) begin
            note_mismatch($sformatf("box_width reads %0d, expected %0d",
                                    readback[BOX_W-1:0], cfg_box_width));
        end
    endtask

    task automatic configure(input logic [DT_W-1:0] dt, input logic [BOX_W-1:0] box);
        wait_idle();
        write_register(ADDR_TIME_STEP, APB_DATA_W'(dt));
        // The bus returns to idle between the two transfers.
        @(posedge i_clk);
        write_register(ADDR_BOX_WIDTH, APB_DATA_W'(box));
    endtask

    task automatic run_random(input int count, input int hold_at);
        t_result none;
        none = '0;
        for (int i = 0; i < count; i++) begin
            if (i == hold_at) begin
                hold_request = 1'b1;
            end
            send_item(draw_item(), 1'b0, none);
        end
    endtask

    initial begin
        int tie;
        tie = 131072;   // force * 1048 lands exactly halfway at the half kick
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        fork
            drain_results();
        join_none

        // Extremes, saturation, wrapping and rounding ties at the reset settings.
        add_row(KIND_LOAD, 0, AXIS_X, 0, 0, 0, 1, 0, 0, 0, 0);
        add_row(KIND_LOAD, 1023, AXIS_Z, VAL_MAX, VAL_MAX, VAL_MAX, 1, VAL_MAX, VAL_MAX, 0, 0);
        add_row(KIND_LOAD, 1022, AXIS_Y, VAL_MIN, VAL_MIN, VAL_MIN, 1, VAL_MIN, VAL_MIN, 0, 0);
        add_row(KIND_DRIFT, 1023, AXIS_Z, 0, 0, 0, 0, 0, 0, 0, 0);
        add_row(KIND_DRIFT, 1022, AXIS_Y, 0, 0, 0, 0, 0, 0, 0, 0);
        add_row(KIND_KICK, 1023, AXIS_Z, VAL_MAX, 0, 0, 0, 0, 0, 0, 0);
        add_row(KIND_KICK, 1022, AXIS_Y, VAL_MIN, 0, 0, 0, 0, 0, 0, 0);
        add_row(KIND_DRIFT, 0, AXIS_X, 0, 0, 0, 0, 0, 0, 0, 0);
        add_row(KIND_KICK, 0, AXIS_X, 0, 0, 0, 0, 0, 0, 0, 0);
        add_row(KIND_LOAD, 6, AXIS_X, tie, 5 << 20, 0, 1, 5 << 20, 0, 0, 0);
        add_row(KIND_KICK, 6, AXIS_X, tie, 0, 0, 0, 0, 0, 0, 0);
        add_row(KIND_KICK, 6, AXIS_X, -tie, 0, 0, 0, 0, 0, 0, 0);
        add_row(KIND_DRIFT, 6, AXIS_X, 0, 0, 0, 0, 0, 0, 0, 0);
        add_row(KIND_LOAD, 2, AXIS_Y, -5, -1, 1000, 1, -1, 1000, 0, 0);
        add_row(KIND_KICK, 2, AXIS_Y, -5, 0, 0, 0, 0, 0, 0, 0);
        add_row(KIND_LOAD, 3, AXIS_Z, 0, 10485760, 0, 1, 10485760, 0, 0, 0);
        add_row(KIND_KICK, 3, AXIS_Z, 0, 0, 0, 0, 0, 0, 0, 0);
        add_row(KIND_LOAD, 4, AXIS_X, 7, 10485759, -1, 1, 10485759, -1, 0, 0);
        add_row(KIND_KICK, 4, AXIS_X, 7, 0, 0, 0, 0, 0, 0, 0);
        add_row(KIND_DRIFT, 4, AXIS_X, 0, 0, 0, 0, 0, 0, 0, 0);
        add_row(KIND_DRIFT, 4, AXIS_X, 0, 0, 0, 0, 0, 0, 0, 0);
        add_row(KIND_UNUSED, 7, AXIS_X, 123, 456, 789, 1, 0, 0, 0, 0);
        add_row(KIND_LOAD, 8, AXIS_NONE, 11, 22, 33, 1, 0, 0, 0, 0);
        add_row(KIND_DRIFT, 1023, AXIS_NONE, 0, 0, 0, 1, 0, 0, 0, 0);
        foreach (directed_rows[i]) begin
            send_item(directed_rows[i].cmd, directed_rows[i].typed, directed_rows[i].want);
        end

        run_random(150, -1);
        configure('0, 31'd1);
        run_random(100, -1);
        configure({DT_W{1'b1}}, {BOX_W{1'b1}});
        run_random(150, 30);
        configure(DT_W'($urandom), BOX_W'($urandom_range(1, 32'h7FFFFFFF)));
        run_random(150, -1);
        // A zero box width makes every kick leave its position as it is and flag it.
        configure(TIME_STEP_RST, '0);
        run_random(80, -1);
        configure(DT_W'($urandom_range(1, 4096)), BOX_WIDTH_RST);
        run_random(170, -1);
        wait_idle();

        if (mismatches == 0) begin
            $display("velocity_verlet_periodic_update: match");
        end else begin
            $display("velocity_verlet_periodic_update: mismatch");
        end
        $finish;
    end

endmodule
